FILE: sv/pfc_pkg.sv
// Shared types, constants and helper functions of the pixel format converter.
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

  localparam int unsigned PixW  = 32;
  localparam int unsigned MaxW  = 16;
  localparam int unsigned PosW  = 5;
  localparam int unsigned NbW   = 3;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned DataW = 16;
  localparam int unsigned ChanW = 24;
  localparam int unsigned CntW  = 5;
  localparam int unsigned ShW   = 7;

  // Exact layouts that only need byte reordering.
  localparam logic [MaxW-1:0] Max5 = 16'd31;
  localparam logic [MaxW-1:0] Max6 = 16'd63;
  localparam logic [MaxW-1:0] Max8 = 16'd255;
  localparam logic [PosW-1:0] Pos565R = 5'd11;
  localparam logic [PosW-1:0] Pos565G = 5'd5;
  localparam logic [PosW-1:0] Pos888R = 5'd16;
  localparam logic [PosW-1:0] Pos888G = 5'd8;
  localparam logic [PosW-1:0] PosZero = 5'd0;

  // Channel tops and widths of the local layouts.
  localparam logic [CntW-1:0] Top16R = 5'd16;
  localparam logic [CntW-1:0] Top16G = 5'd11;
  localparam logic [CntW-1:0] Top16B = 5'd5;
  localparam logic [CntW-1:0] Top24R = 5'd24;
  localparam logic [CntW-1:0] Top24G = 5'd16;
  localparam logic [CntW-1:0] Top24B = 5'd8;
  localparam logic [CntW-1:0] Lim5   = 5'd5;
  localparam logic [CntW-1:0] Lim6   = 5'd6;
  localparam logic [CntW-1:0] Lim8   = 5'd8;

  localparam logic [NbW-1:0] Nb1 = 3'd1;
  localparam logic [NbW-1:0] Nb2 = 3'd2;
  localparam logic [NbW-1:0] Nb3 = 3'd3;
  localparam logic [NbW-1:0] Nb4 = 3'd4;

  localparam logic [PixW-1:0] Mask8  = 32'h0000_00ff;
  localparam logic [PixW-1:0] Mask16 = 32'h0000_ffff;
  localparam logic [PixW-1:0] Mask24 = 32'h00ff_ffff;

  typedef enum logic [IdxW-1:0] {
    REG_RED_MAX   = 3'd0,
    REG_GREEN_MAX = 3'd1,
    REG_BLUE_MAX  = 3'd2,
    REG_RED_POS   = 3'd3,
    REG_GREEN_POS = 3'd4,
    REG_BLUE_POS  = 3'd5,
    REG_BPP       = 3'd6,
    REG_BIG_END   = 3'd7
  } reg_idx_e;

  // Per-item conversion settings, decoded from the register file.
  typedef struct packed {
    logic [NbW-1:0]          nb;
    logic                    wide;
    logic                    generic;
    logic                    swap;
    logic signed [ShW-1:0]   sr;
    logic signed [ShW-1:0]   sg;
    logic signed [ShW-1:0]   sb;
    logic [ChanW-1:0]        mr;
    logic [ChanW-1:0]        mg;
    logic [ChanW-1:0]        mb;
  } cfg_t;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            last;
    cfg_t            cfg;
  } s1_t;

  typedef struct packed {
    logic [PixW-1:0]  c;
    logic             last;
    logic             wide;
    logic             generic;
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } s2_t;

  // Smallest n with v <= 2^n; each compare is independent.
  function automatic logic [CntW-1:0] bit_count(input logic [MaxW-1:0] v);
    logic [CntW-1:0] n;
    n = '0;
    for (int i = MaxW; i >= 0; i--) begin
      if ({1'b0, v} <= (17'd1 << i)) begin
        n = CntW'(i);
      end
    end
    return n;
  endfunction

  // Ones from bit top-ones up to bit top-1.
  function automatic logic [ChanW-1:0] field_mask(input logic [CntW-1:0] ones,
                                                  input logic [CntW-1:0] top);
    logic [ChanW-1:0] m;
    for (int i = 0; i < ChanW; i++) begin
      m[i] = (CntW'(i) < top) && ({1'b0, CntW'(i)} >= ({1'b0, top} - {1'b0, ones}));
    end
    return m;
  endfunction

  function automatic logic [CntW-1:0] min_cnt(input logic [CntW-1:0] a,
                                              input logic [CntW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PixW-1:0] swap16(input logic [PixW-1:0] v);
    return {16'h0000, v[7:0], v[15:8]};
  endfunction

  function automatic logic [PixW-1:0] swap24(input logic [PixW-1:0] v);
    return {8'h00, v[7:0], v[15:8], v[23:16]};
  endfunction

  function automatic logic [PixW-1:0] swap32(input logic [PixW-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

`default_nettype wire

FILE: sv/pfc_if.sv
// Word channels of the pixel format converter: input pixels, output pixels, register writes.
`timescale 1ns / 1ps
`default_nettype none

interface pfc_in_if;
  import pfc_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_in;
  logic            last_in;
  modport source (output valid, output pixel_in, output last_in, input ready);
  modport sink   (input valid, input pixel_in, input last_in, output ready);
endinterface

interface pfc_out_if;
  import pfc_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_out;
  logic            last_out;
  modport source (output valid, output pixel_out, output last_out, input ready);
  modport sink   (input valid, input pixel_out, input last_out, output ready);
endinterface

interface pfc_cfg_if;
  import pfc_pkg::*;
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  index;
  logic [DataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/pfc_cfg.sv
// Register file and format decode of the pixel format converter.
`timescale 1ns / 1ps
`default_nettype none

module pfc_cfg (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  pfc_cfg_if.sink       cfg_i,
  output pfc_pkg::cfg_t cfg_o
);
  import pfc_pkg::*;

  logic [MaxW-1:0] red_max_q, green_max_q, blue_max_q;
  logic [PosW-1:0] red_pos_q, green_pos_q, blue_pos_q;
  logic [NbW-1:0]  bpp_q;
  logic            big_end_q;

  logic [CntW-1:0] cr, cg, cb;
  logic [CntW-1:0] top_r, top_g, top_b;
  logic [CntW-1:0] lr, lg, lb;
  logic            exact565, exact888, nb_rgb;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_max_q   <= Max8;
      green_max_q <= Max8;
      blue_max_q  <= Max8;
      red_pos_q   <= Pos888R;
      green_pos_q <= Pos888G;
      blue_pos_q  <= PosZero;
      bpp_q       <= Nb4;
      big_end_q   <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_RED_MAX:   red_max_q   <= cfg_i.data;
        REG_GREEN_MAX: green_max_q <= cfg_i.data;
        REG_BLUE_MAX:  blue_max_q  <= cfg_i.data;
        REG_RED_POS:   red_pos_q   <= cfg_i.data[PosW-1:0];
        REG_GREEN_POS: green_pos_q <= cfg_i.data[PosW-1:0];
        REG_BLUE_POS:  blue_pos_q  <= cfg_i.data[PosW-1:0];
        REG_BPP:       bpp_q       <= cfg_i.data[NbW-1:0];
        REG_BIG_END:   big_end_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    exact565 = (red_max_q == Max5) && (green_max_q == Max6) && (blue_max_q == Max5) &&
               (red_pos_q == Pos565R) && (green_pos_q == Pos565G) && (blue_pos_q == PosZero);
    exact888 = (red_max_q == Max8) && (green_max_q == Max8) && (blue_max_q == Max8) &&
               (red_pos_q == Pos888R) && (green_pos_q == Pos888G) && (blue_pos_q == PosZero);
    nb_rgb   = (bpp_q == Nb2) || (bpp_q == Nb3) || (bpp_q == Nb4);

    cr = bit_count(red_max_q);
    cg = bit_count(green_max_q);
    cb = bit_count(blue_max_q);

    cfg_o.nb   = bpp_q;
    cfg_o.wide = (bpp_q == Nb3) || (bpp_q == Nb4);
    cfg_o.swap = nb_rgb && !big_end_q;
    cfg_o.generic = ((bpp_q == Nb2) && !exact565) || (cfg_o.wide && !exact888);

    if (cfg_o.wide) begin
      top_r = Top24R; top_g = Top24G; top_b = Top24B;
      lr = min_cnt(cr, Lim8); lg = min_cnt(cg, Lim8); lb = min_cnt(cb, Lim8);
    end else begin
      top_r = Top16R; top_g = Top16G; top_b = Top16B;
      lr = min_cnt(cr, Lim5); lg = min_cnt(cg, Lim6); lb = min_cnt(cb, Lim5);
    end

    // Signed shift is top - bit count - position; positive means left.
    cfg_o.sr = signed'(ShW'(top_r)) - signed'(ShW'(cr)) - signed'(ShW'(red_pos_q));
    cfg_o.sg = signed'(ShW'(top_g)) - signed'(ShW'(cg)) - signed'(ShW'(green_pos_q));
    cfg_o.sb = signed'(ShW'(top_b)) - signed'(ShW'(cb)) - signed'(ShW'(blue_pos_q));
    cfg_o.mr = field_mask(lr, top_r);
    cfg_o.mg = field_mask(lg, top_g);
    cfg_o.mb = field_mask(lb, top_b);
  end

`ifndef SYNTHESIS
  // A channel mask never holds more than eight ones.
  a_mask_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(cfg_o.mr) <= 8) && ($countones(cfg_o.mg) <= 8) &&
    ($countones(cfg_o.mb) <= 8))
    else $error("channel mask wider than eight bits");
`endif

endmodule

`default_nettype wire

FILE: sv/pfc_align.sv
// Second pipeline stage: byte reordering and per-channel shift and mask.
`timescale 1ns / 1ps
`default_nettype none

module pfc_align (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire pfc_pkg::s1_t  data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output pfc_pkg::s2_t       data_o
);
  import pfc_pkg::*;

  logic valid_q;
  s2_t  data_q, data_d;
  logic [PixW-1:0] c;

  // Signed move: left for a positive amount, right otherwise, zero past 31.
  function automatic logic [PixW-1:0] move_bits(input logic [PixW-1:0] v,
                                                input logic signed [ShW-1:0] s);
    logic [ShW-1:0] neg;
    neg = ShW'(-s);
    if (s > 0) begin
      return (s >= 32) ? '0 : (v << s[4:0]);
    end
    return (neg >= ShW'(32)) ? '0 : (v >> neg[4:0]);
  endfunction

  always_comb begin
    c = data_i.pixel;
    if (data_i.cfg.swap) begin
      case (data_i.cfg.nb)
        Nb2:     c = swap16(data_i.pixel);
        Nb3:     c = swap24(data_i.pixel);
        default: c = swap32(data_i.pixel);
      endcase
    end
    data_d.c       = c;
    data_d.last    = data_i.last;
    data_d.wide    = data_i.cfg.wide;
    data_d.generic = data_i.cfg.generic;
    data_d.r = ChanW'(move_bits(c, data_i.cfg.sr)) & data_i.cfg.mr;
    data_d.g = ChanW'(move_bits(c, data_i.cfg.sg)) & data_i.cfg.mg;
    data_d.b = ChanW'(move_bits(c, data_i.cfg.sb)) & data_i.cfg.mb;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

`ifndef SYNTHESIS
  // For 2-byte pixels the channels land inside the low 16 bits.
  a_narrow_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && data_q.generic && !data_q.wide) |->
      ((data_q.r[ChanW-1:16] | data_q.g[ChanW-1:16] | data_q.b[ChanW-1:16]) == '0))
    else $error("565 channel outside the low 16 bits");
`endif

endmodule

`default_nettype wire

FILE: sv/pfc_merge.sv
// Third pipeline stage: channel sum, width cut and result selection.
`timescale 1ns / 1ps
`default_nettype none

module pfc_merge (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  output logic              ready_o,
  input  wire pfc_pkg::s2_t data_i,
  pfc_out_if.source         out_o
);
  import pfc_pkg::*;

  logic            valid_q;
  logic [PixW-1:0] pixel_q, pixel_d;
  logic            last_q;
  logic [ChanW-1:0] sum;

  always_comb begin
    sum = data_i.r + data_i.g + data_i.b;
    if (!data_i.generic) begin
      pixel_d = data_i.c;
    end else if (data_i.wide) begin
      pixel_d = {8'h00, sum};
    end else begin
      pixel_d = {16'h0000, sum[15:0]};
    end
  end

  assign ready_o         = !valid_q || out_o.ready;
  assign out_o.valid     = valid_q;
  assign out_o.pixel_out = pixel_q;
  assign out_o.last_out  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pixel_q <= pixel_d;
      last_q  <= data_i.last;
    end
  end

`ifndef SYNTHESIS
  // A word from the previous stage is taken exactly when this stage has room.
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o) |=> valid_q)
    else $error("accepted word did not reach the output register");
`endif

endmodule

`default_nettype wire

FILE: sv/pixel_format_converter.sv
// Top level of the pixel format converter: input stage and pipeline assembly.
// Pipeline: three register stages; an accepted word moves from the stage 1
// register through the pfc_align register to the pfc_merge output register.
// Throughput: one word per cycle; each stage holds while the next one is full.
// Reset: rst_ni clears all stage valid bits and loads the register file with a
// big-endian 4-byte R8G8B8 layout (max 255, positions 16/8/0).
`timescale 1ns / 1ps
`default_nettype none

module pixel_format_converter (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pfc_cfg_if.sink   cfg_i,
  pfc_in_if.sink    in_i,
  pfc_out_if.source out_o
);
  import pfc_pkg::*;

  // The decoded settings travel with each word, so a later register write
  // never disturbs words already in flight.
  cfg_t cfg;

  logic s1_valid_q;
  s1_t  s1_q, s1_d;
  logic s1_ready;
  logic s2_ready;

  logic s2_valid;
  s2_t  s2_data;
  logic s3_ready;

  pfc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Stage 1 keeps only the bytes that belong to the pixel. Out-of-range sizes
  // keep the whole word.
  always_comb begin
    s1_d.last = in_i.last_in;
    s1_d.cfg  = cfg;
    case (cfg.nb)
      Nb1:     s1_d.pixel = in_i.pixel_in & Mask8;
      Nb2:     s1_d.pixel = in_i.pixel_in & Mask16;
      Nb3:     s1_d.pixel = in_i.pixel_in & Mask24;
      default: s1_d.pixel = in_i.pixel_in;
    endcase
  end

  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_i.valid) begin
      s1_q <= s1_d;
    end
  end

  // Stage 2 reorders bytes and shifts each channel into place.
  pfc_align u_align (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .ready_o (s2_ready),
    .data_i  (s1_q),
    .valid_o (s2_valid),
    .ready_i (s3_ready),
    .data_o  (s2_data)
  );

  // Stage 3 sums the channels and drives the output word.
  pfc_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s3_ready),
    .data_i  (s2_data),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  // A stalled first stage keeps its word until the next stage takes it.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_ready) |=> (s1_valid_q && $stable(s1_q)))
    else $error("stage 1 word changed while stalled");
`endif

endmodule

`default_nettype wire

FILE: test/pfc_checker.sv
// Checker of the pixel format converter: watches all channels, predicts output words, compares.
`timescale 1ns / 1ps

module pfc_checker
  import pfc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  pfc_cfg_if   cfg_mon,
  pfc_in_if    in_mon,
  pfc_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            last;
  } converted_word_t;

  // Local copy of the register file, updated on every accepted register write.
  logic [MaxW-1:0] red_max_q, green_max_q, blue_max_q;
  logic [PosW-1:0] red_pos_q, green_pos_q, blue_pos_q;
  logic [NbW-1:0]  bytes_q;
  logic            big_end_q;

  converted_word_t expected_words[$];
  int              failures = 0;

  assign fail_count_o = failures;

  // Smallest n for which the channel maximum is at most 2^n.
  function automatic int channel_bits(logic [MaxW-1:0] maxv);
    int n;
    n = 0;
    while (n < 32 && longint'(maxv) > (longint'(1) << n)) begin
      n++;
    end
    return n;
  endfunction

  function automatic logic [PixW-1:0] reordered(logic [PixW-1:0] px, logic [NbW-1:0] nb);
    case (nb)
      Nb2:     return {16'h0000, px[7:0], px[15:8]};
      Nb3:     return {8'h00, px[7:0], px[15:8], px[23:16]};
      default: return {px[7:0], px[15:8], px[23:16], px[31:24]};
    endcase
  endfunction

  // Moves one server channel under its local top and keeps only its local bits.
  function automatic logic [PixW-1:0] placed_channel(logic [PixW-1:0] c, int top, int width,
                                                     int limit, int pos);
    int              shift;
    int              ones;
    logic [PixW-1:0] moved;
    logic [PixW-1:0] mask;
    shift = top - width - pos;
    if (shift > 0) begin
      moved = (shift >= 32) ? '0 : c << shift;
    end else begin
      moved = (-shift >= 32) ? '0 : c >> (-shift);
    end
    ones = (width < limit) ? width : limit;
    mask = ((32'd1 << ones) - 32'd1) << (top - ones);
    return moved & mask;
  endfunction

  function automatic logic [PixW-1:0] converted_pixel(logic [PixW-1:0] raw);
    logic [PixW-1:0] px;
    logic [PixW-1:0] c;
    logic [PixW-1:0] total;
    logic            little;
    logic            exact565;
    logic            exact888;
    little   = !big_end_q;
    exact565 = red_max_q == Max5 && green_max_q == Max6 && blue_max_q == Max5 &&
               red_pos_q == Pos565R && green_pos_q == Pos565G && blue_pos_q == PosZero;
    exact888 = red_max_q == Max8 && green_max_q == Max8 && blue_max_q == Max8 &&
               red_pos_q == Pos888R && green_pos_q == Pos888G && blue_pos_q == PosZero;
    if (bytes_q < Nb1 || bytes_q > Nb4) begin
      return raw;
    end
    if (bytes_q == Nb1) begin
      return raw & Mask8;
    end
    if (bytes_q == Nb2) begin
      px = raw & Mask16;
      if (exact565) begin
        return little ? reordered(px, Nb2) : px;
      end
    end else begin
      px = (bytes_q == Nb3) ? (raw & Mask24) : raw;
      if (exact888) begin
        return little ? reordered(px, bytes_q) : px;
      end
    end
    c = little ? reordered(px, bytes_q) : px;
    if (bytes_q == Nb2) begin
      total = placed_channel(c, int'(Top16R), channel_bits(red_max_q), int'(Lim5),
                             int'(red_pos_q))
            + placed_channel(c, int'(Top16G), channel_bits(green_max_q), int'(Lim6),
                             int'(green_pos_q))
            + placed_channel(c, int'(Top16B), channel_bits(blue_max_q), int'(Lim5),
                             int'(blue_pos_q));
      return total & Mask16;
    end
    total = placed_channel(c, int'(Top24R), channel_bits(red_max_q), int'(Lim8),
                           int'(red_pos_q))
          + placed_channel(c, int'(Top24G), channel_bits(green_max_q), int'(Lim8),
                           int'(green_pos_q))
          + placed_channel(c, int'(Top24B), channel_bits(blue_max_q), int'(Lim8),
                           int'(blue_pos_q));
    return total & Mask24;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    converted_word_t want;
    if (!rst_ni) begin
      red_max_q   <= Max8;
      green_max_q <= Max8;
      blue_max_q  <= Max8;
      red_pos_q   <= Pos888R;
      green_pos_q <= Pos888G;
      blue_pos_q  <= PosZero;
      bytes_q     <= Nb4;
      big_end_q   <= 1'b1;
      expected_words.delete();
      pending_o   <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (reg_idx_e'(cfg_mon.index))
          REG_RED_MAX:   red_max_q   <= cfg_mon.data;
          REG_GREEN_MAX: green_max_q <= cfg_mon.data;
          REG_BLUE_MAX:  blue_max_q  <= cfg_mon.data;
          REG_RED_POS:   red_pos_q   <= cfg_mon.data[PosW-1:0];
          REG_GREEN_POS: green_pos_q <= cfg_mon.data[PosW-1:0];
          REG_BLUE_POS:  blue_pos_q  <= cfg_mon.data[PosW-1:0];
          REG_BPP:       bytes_q     <= cfg_mon.data[NbW-1:0];
          REG_BIG_END:   big_end_q   <= cfg_mon.data[0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output word: pixel_out %h last_out %b",
                 out_mon.pixel_out, out_mon.last_out);
          failures++;
        end else begin
          want = expected_words.pop_front();
          if (out_mon.pixel_out !== want.pixel) begin
            $error("pixel_out mismatch: expected %h, actual %h", want.pixel, out_mon.pixel_out);
            failures++;
          end
          if (out_mon.last_out !== want.last) begin
            $error("last_out mismatch: expected %b, actual %b", want.last, out_mon.last_out);
            failures++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        want.pixel = converted_pixel(in_mon.pixel_in);
        want.last  = in_mon.last_in;
        expected_words.push_back(want);
      end
      pending_o <= expected_words.size();
    end
  end

endmodule

FILE: test/testbench.sv
// Top of the pixel format converter testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
  import pfc_pkg::*;

  // A server pixel format as seen through the register file.
  typedef struct packed {
    logic [MaxW-1:0] red_max;
    logic [MaxW-1:0] green_max;
    logic [MaxW-1:0] blue_max;
    logic [PosW-1:0] red_pos;
    logic [PosW-1:0] green_pos;
    logic [PosW-1:0] blue_pos;
    logic [NbW-1:0]  bytes;
    logic            big_end;
  } server_format_t;

  // Phases with hand-picked formats come first, then formats drawn at random.
  localparam int FixedPhases    = 18;
  localparam int RandomPhases   = 8;
  localparam int DirectedPhases = 12;
  localparam int WordsPerPhase  = 44;
  // The pipeline is three stages deep; a few spare cycles cover it.
  localparam int DrainCycles    = 6;
  // With 65 percent stalls an idle run as long as WatchdogLimit is vanishingly rare,
  // so reaching it without any accepted word can only mean a hung handshake.
  localparam int WatchdogLimit  = 2000;

  logic clk_i = 1'b0;
  logic rst_ni;

  int send_idle_pct;
  int stall_pct;
  int failures;
  int words_pending;
  int quiet_cycles = 0;

  pfc_cfg_if cfg_ch ();
  pfc_in_if  pix_in_ch ();
  pfc_out_if pix_out_ch ();

  pixel_format_converter u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (pix_in_ch),
    .out_o  (pix_out_ch)
  );

  pfc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_ch),
    .in_mon       (pix_in_ch),
    .out_mon      (pix_out_ch),
    .fail_count_o (failures),
    .pending_o    (words_pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The receiver stalls at random, at the rate of the current idling phase.
  always @(posedge clk_i) begin
    pix_out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // The watchdog ends the run when no word has moved on any channel for too long.
  always @(posedge clk_i) begin
    if ((cfg_ch.valid && cfg_ch.ready) || (pix_in_ch.valid && pix_in_ch.ready) ||
        (pix_out_ch.valid && pix_out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hand-picked formats: every byte-reordering case in both byte orders, the
  // colour-map pass-through, the illegal pixel sizes, generic layouts, and
  // channel extremes including overlapping and out-of-range fields.
  function automatic server_format_t fixed_format(int k);
    case (k)
      1:  return server_format_t'{Max8, Max8, Max8, Pos888R, Pos888G, PosZero, Nb4, 1'b0};
      2:  return server_format_t'{Max8, Max8, Max8, Pos888R, Pos888G, PosZero, Nb3, 1'b1};
      3:  return server_format_t'{Max8, Max8, Max8, Pos888R, Pos888G, PosZero, Nb3, 1'b0};
      4:  return server_format_t'{Max5, Max6, Max5, Pos565R, Pos565G, PosZero, Nb2, 1'b1};
      5:  return server_format_t'{Max5, Max6, Max5, Pos565R, Pos565G, PosZero, Nb2, 1'b0};
      6:  return server_format_t'{Max8, 16'd1, 16'd1, 5'd3, 5'd2, 5'd1, Nb1, 1'b0};
      7:  return server_format_t'{Max8, Max8, Max8, Pos888R, Pos888G, PosZero, 3'd0, 1'b0};
      8:  return server_format_t'{Max5, Max6, Max5, Pos565R, Pos565G, PosZero, 3'd5, 1'b1};
      9:  return server_format_t'{16'd7, 16'd7, 16'd3, 5'd5, 5'd2, 5'd0, 3'd6, 1'b0};
      10: return server_format_t'{Max8, Max8, Max8, Pos888R, Pos888G, PosZero, 3'd7, 1'b1};
      11: return server_format_t'{Max5, Max5, Max5, 5'd10, 5'd5, PosZero, Nb2, 1'b0};
      12: return server_format_t'{Max8, Max8, Max8, PosZero, Pos888G, Pos888R, Nb4, 1'b1};
      13: return server_format_t'{16'hffff, 16'hffff, 16'hffff, 5'd31, 5'd31, 5'd31, Nb4, 1'b0};
      14: return server_format_t'{16'd0, 16'd0, 16'd0, PosZero, PosZero, PosZero, Nb3, 1'b1};
      15: return server_format_t'{16'd1, 16'd1, 16'd1, 5'd31, 5'd31, 5'd31, Nb2, 1'b0};
      16: return server_format_t'{Max5, Max6, Max5, Pos565R, 5'd6, PosZero, Nb2, 1'b0};
      17: return server_format_t'{Max8, Max8, 16'd256, Pos888R, Pos888G, PosZero, Nb3, 1'b0};
      default: return server_format_t'{Max8, Max8, Max8, Pos888R, Pos888G, PosZero, Nb4, 1'b1};
    endcase
  endfunction

  // Channel maxima come from the whole range, from powers of two and from just
  // below them, and from the degenerate values around zero.
  function automatic logic [MaxW-1:0] random_max();
    case ($urandom_range(3))
      0:       return MaxW'($urandom_range(65535));
      1:       return MaxW'((32'd1 << $urandom_range(16)) - 1);
      2:       return MaxW'(32'd1 << $urandom_range(15));
      default: return MaxW'($urandom_range(3));
    endcase
  endfunction

  function automatic server_format_t random_format();
    server_format_t f;
    f.red_max   = random_max();
    f.green_max = random_max();
    f.blue_max  = random_max();
    f.red_pos   = PosW'($urandom);
    f.green_pos = PosW'($urandom);
    f.blue_pos  = PosW'($urandom);
    // Mostly legal pixel sizes; now and then an illegal one.
    f.bytes     = ($urandom_range(5) == 0) ? NbW'($urandom) : NbW'($urandom_range(4, 2));
    f.big_end   = 1'($urandom);
    return f;
  endfunction

  // Register fields narrower than the write data get random junk above them
  // half of the time; only the low bits may take effect.
  function automatic logic [DataW-1:0] reg_word(logic [DataW-1:0] field, int bits);
    logic [DataW-1:0] junk;
    junk = DataW'($urandom) << bits;
    return ($urandom_range(1) == 1) ? (field | junk) : field;
  endfunction

  function automatic logic [PixW-1:0] random_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1 << $urandom_range(31);
      default: return PixW'($urandom);
    endcase
  endfunction

  // Leaves valid high after the write is accepted so that back-to-back writes
  // never lower and raise it in one time step; the caller drops it at the end.
  task automatic write_reg(reg_idx_e idx, logic [DataW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic load_format(server_format_t f);
    write_reg(REG_RED_MAX, f.red_max);
    write_reg(REG_GREEN_MAX, f.green_max);
    write_reg(REG_BLUE_MAX, f.blue_max);
    write_reg(REG_RED_POS, reg_word(DataW'(f.red_pos), PosW));
    write_reg(REG_GREEN_POS, reg_word(DataW'(f.green_pos), PosW));
    write_reg(REG_BLUE_POS, reg_word(DataW'(f.blue_pos), PosW));
    write_reg(REG_BPP, reg_word(DataW'(f.bytes), NbW));
    write_reg(REG_BIG_END, reg_word(DataW'(f.big_end), 1));
    cfg_ch.valid <= 1'b0;
  endtask

  // Random idle cycles go in front of the word; valid then stays high until
  // the converter takes it.
  task automatic send_pixel(logic [PixW-1:0] px, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in_ch.valid    <= 1'b1;
    pix_in_ch.pixel_in <= px;
    pix_in_ch.last_in  <= lst;
    do @(posedge clk_i); while (!pix_in_ch.ready);
  endtask

  initial begin
    send_idle_pct = 0;
    stall_pct     = 0;
    rst_ni             <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_RED_MAX;
    cfg_ch.data        <= '0;
    pix_in_ch.valid    <= 1'b0;
    pix_in_ch.pixel_in <= '0;
    pix_in_ch.last_in  <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < FixedPhases + RandomPhases; phase++) begin
      // Rotate through the idling modes so that gaps and stalls land on
      // different formats, with unthrottled phases in between.
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 65; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 65; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase

      // The first phase runs on the reset format; all others load one.
      if (phase > 0) begin
        load_format(phase < FixedPhases ? fixed_format(phase) : random_format());
      end

      // Directed words: all zeros, all ones and alternating patterns, with the
      // buffer-end flag taking both values.
      if (phase < DirectedPhases) begin
        send_pixel(phase[0] ? 32'hffff_ffff : 32'h0000_0000, phase[0]);
        send_pixel(phase[0] ? 32'h5a5a_a5a5 : 32'ha5a5_5a5a, !phase[0]);
      end

      repeat (WordsPerPhase) begin
        send_pixel(random_pixel(), $urandom_range(7) == 0);
      end
      pix_in_ch.valid <= 1'b0;

      // Registers may only change once every word of this phase is out. The
      // checker first records the word just accepted, so words_pending counts it.
      @(posedge clk_i);
      while (words_pending != 0) @(posedge clk_i);
      repeat (DrainCycles) @(posedge clk_i);
    end

    if (failures == 0 && words_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
